[hw/rtl/wsfs_pkg.sv]
// Shared types, constants and helpers of the WS2812 frame serializer.
package wsfs_pkg;

    localparam int WSFS_LED_COUNT = 64;   // default frame buffer depth
    localparam int WSFS_LANES     = 4;    // pixels per memory row
    localparam int PIX_W          = 24;   // G:R:B
    localparam int BITS_PER_LED   = 24;

    // action codes
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_WRITE     = 3'd1;
    localparam logic [2:0] ACT_CLEAR     = 3'd2;
    localparam logic [2:0] ACT_CLEAR_ALL = 3'd3;
    localparam logic [2:0] ACT_REFRESH   = 3'd4;

    // register indexes
    localparam logic [2:0] REG_ONE_HIGH   = 3'd0;
    localparam logic [2:0] REG_ZERO_HIGH  = 3'd1;
    localparam logic [2:0] REG_BIT_PERIOD = 3'd2;
    localparam logic [2:0] REG_RESET_LOW  = 3'd3;
    localparam logic [2:0] REG_LED_COUNT  = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } wsfs_in_t;

    typedef struct packed {
        logic line_out;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } wsfs_out_t;

    typedef struct packed {
        logic [7:0]  one_high_ticks;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  bit_period_ticks;
        logic [15:0] reset_low_ticks;
        logic [6:0]  led_count;
    } wsfs_cfg_t;

    // write side of the frame memory
    typedef struct packed {
        logic             en;
        logic             clr_all;
        logic [5:0]       idx;
        logic [PIX_W-1:0] pixel;
    } wsfs_mem_wr_t;

    // index width for n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

[hw/rtl/ws2812_frame_serializer_unit.sv]
// WS2812 frame serializer top level: action decode, line sequencer, memory.
// A beat's result is registered in the output register, or in its skid stage while m_ stalls.
// Throughput: one action beat per cycle, held only by the two-entry result buffer.
// Pixel fetch runs one LED ahead through the registered frame memory read port.
// Reset (aresetn low, synchronous): idle line, registers at defaults, buffer black.
// Buffer clear is by per-row valid bits, so no clearing pass is needed.
module ws2812_frame_serializer_unit #(
    parameter int LED_COUNT = wsfs_pkg::WSFS_LED_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,
    // action beats
    input  logic                s_valid,
    output logic                s_ready,
    input  wsfs_pkg::wsfs_in_t  s_data,
    // result beats
    output logic                m_valid,
    input  logic                m_ready,
    output wsfs_pkg::wsfs_out_t m_data,
    // register writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import wsfs_pkg::*;

    localparam int LP_W = $clog2(LED_COUNT + 1);  // LED pointer, holds the count
    localparam int MA_W = idx_w(LED_COUNT);       // frame memory address

    wsfs_cfg_t    cfg;
    wsfs_mem_wr_t mem_wr;
    wsfs_out_t    res;
    logic         acc;
    logic         rd_req;
    logic         rd_en;
    logic [LP_W:0] rd_wide;
    logic [PIX_W-1:0] rd_pixel;

    // line sequencer state
    logic             active_reg, active_next;
    logic             sr_reg, sr_next;         // in reset-low interval
    logic [15:0]      tc_reg, tc_next;         // tick counter
    logic [LP_W-1:0]  lp_reg, lp_next;         // LED pointer
    logic [4:0]       bp_reg, bp_next;         // bit pointer, MSB first
    logic [PIX_W-1:0] cur_pix_reg, cur_pix_next;  // color of LED being sent
    logic [PIX_W-1:0] led0_reg, led0_next;     // shadow of LED 0 for frame start

    // scratch
    logic [2:0]       act;
    logic             is_wr;
    logic             idx_ok;
    logic [15:0]      rl;
    logic [7:0]       period;
    logic [7:0]       high;
    logic [15:0]      tc_inc;
    logic [4:0]       bp_inc;
    logic [LP_W-1:0]  lp_inc;
    logic [LP_W-1:0]  eff_cnt;

    assign cfg_ready = 1'b1;

    wsfs_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    wsfs_frame_mem #(.LED_COUNT(LED_COUNT)) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (mem_wr),
        .rd_en    (rd_en),
        .rd_addr  (MA_W'(rd_wide)),
        .rd_pixel (rd_pixel)
    );

    wsfs_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc),
        .in_ready  (s_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assign acc = s_valid && s_ready;
    assign act = s_data.action;

    // effective limits; degenerate register values are clamped
    assign rl     = (cfg.reset_low_ticks == 16'd0) ? 16'd1 : cfg.reset_low_ticks;
    assign period = (cfg.bit_period_ticks < 8'd2) ? 8'd2 : cfg.bit_period_ticks;
    always_comb begin
        if (cfg.led_count == 7'd0) begin
            eff_cnt = LP_W'(1);
        end else if (32'(cfg.led_count) > LED_COUNT) begin
            eff_cnt = LP_W'(LED_COUNT);
        end else begin
            eff_cnt = LP_W'(cfg.led_count);
        end
    end

    assign is_wr  = (act == ACT_WRITE) || (act == ACT_CLEAR);
    assign idx_ok = 32'(s_data.led_index) < LED_COUNT;

    always_comb begin
        active_next  = active_reg;
        sr_next      = sr_reg;
        tc_next      = tc_reg;
        lp_next      = lp_reg;
        bp_next      = bp_reg;
        cur_pix_next = cur_pix_reg;
        led0_next    = led0_reg;
        res          = '0;
        mem_wr       = '0;
        rd_req       = 1'b0;
        high         = '0;
        tc_inc       = '0;
        bp_inc       = '0;
        lp_inc       = '0;

        if (acc) begin
            // action decode: buffer is writable only between frames
            if (active_reg) begin
                res.rejected = is_wr || (act == ACT_CLEAR_ALL);
            end else begin
                if (is_wr && idx_ok) begin
                    mem_wr.en    = 1'b1;
                    mem_wr.idx   = s_data.led_index;
                    mem_wr.pixel = (act == ACT_WRITE) ?
                                   {s_data.green, s_data.red, s_data.blue} : '0;
                    if (s_data.led_index == 6'd0) begin
                        led0_next = mem_wr.pixel;
                    end
                end
                if (act == ACT_CLEAR_ALL) begin
                    mem_wr.clr_all = 1'b1;
                    led0_next      = '0;
                end
                if ((act == ACT_CLEAR_ALL) || (act == ACT_REFRESH)) begin
                    active_next  = 1'b1;
                    sr_next      = 1'b1;
                    tc_next      = '0;
                    lp_next      = '0;
                    bp_next      = '0;
                    cur_pix_next = led0_next;
                    rd_req       = 1'b1;   // prefetch LED 1
                end
            end

            // waveform advances every beat
            if (active_next) begin
                res.busy_res = 1'b1;
                tc_inc = tc_next + 16'd1;
                if (sr_next) begin
                    if ((tc_inc == 16'd0) || (tc_inc >= rl)) begin
                        sr_next = 1'b0;
                        tc_next = '0;
                    end else begin
                        tc_next = tc_inc;
                    end
                end else begin
                    high = cur_pix_next[5'd23 - bp_next] ?
                           cfg.one_high_ticks : cfg.zero_high_ticks;
                    res.line_out = tc_next < {8'd0, high};
                    if ((tc_inc == 16'd0) || (tc_inc >= {8'd0, period})) begin
                        tc_next = '0;
                        bp_inc  = bp_next + 5'd1;
                        if (32'(bp_inc) >= BITS_PER_LED) begin
                            bp_next = '0;
                            lp_inc  = lp_next + LP_W'(1);
                            if (lp_inc >= eff_cnt) begin
                                lp_next        = '0;
                                active_next    = 1'b0;
                                res.frame_done = 1'b1;
                            end else begin
                                lp_next      = lp_inc;
                                cur_pix_next = rd_pixel;
                                rd_req       = 1'b1;   // prefetch the LED after
                            end
                        end else begin
                            bp_next = bp_inc;
                        end
                    end else begin
                        tc_next = tc_inc;
                    end
                end
            end
        end
    end

    // next LED to fetch is one past the pointer
    assign rd_wide = {1'b0, lp_next} + (LP_W + 1)'(1);
    assign rd_en   = rd_req && (32'(rd_wide) < LED_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            sr_reg      <= 1'b0;
            tc_reg      <= '0;
            lp_reg      <= '0;
            bp_reg      <= '0;
            led0_reg    <= '0;
        end else begin
            active_reg  <= active_next;
            sr_reg      <= sr_next;
            tc_reg      <= tc_next;
            lp_reg      <= lp_next;
            bp_reg      <= bp_next;
            led0_reg    <= led0_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_pix_reg <= cur_pix_next;
    end

    // between frames the pointers rest at the start
    ap_idle_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (lp_reg == '0 && bp_reg == '0 && !sr_reg))
        else $error("sequencer pointers not parked while idle");

    ap_bp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(bp_reg) < BITS_PER_LED)
        else $error("bit pointer out of range");

    ap_wr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr.en || mem_wr.clr_all) |-> !active_reg)
        else $error("frame buffer modified during a frame");

    ap_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

endmodule

[hw/rtl/wsfs_cfg_regs.sv]
// Configuration register file of the WS2812 frame serializer.
module wsfs_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [15:0]        wr_data,
    output wsfs_pkg::wsfs_cfg_t cfg
);
    import wsfs_pkg::*;

    wsfs_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_high_ticks   <= 8'd19;
            cfg_reg.zero_high_ticks  <= 8'd11;
            cfg_reg.bit_period_ticks <= 8'd30;
            cfg_reg.reset_low_ticks  <= 16'd1200;
            cfg_reg.led_count        <= 7'd64;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_ONE_HIGH:   cfg_reg.one_high_ticks   <= wr_data[7:0];
                REG_ZERO_HIGH:  cfg_reg.zero_high_ticks  <= wr_data[7:0];
                REG_BIT_PERIOD: cfg_reg.bit_period_ticks <= wr_data[7:0];
                REG_RESET_LOW:  cfg_reg.reset_low_ticks  <= wr_data;
                REG_LED_COUNT:  cfg_reg.led_count        <= wr_data[6:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/wsfs_frame_mem.sv]
// Frame buffer memory: rows of pixels, per-row valid bits, registered read.
module wsfs_frame_mem #(
    parameter int LED_COUNT = wsfs_pkg::WSFS_LED_COUNT
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  wsfs_pkg::wsfs_mem_wr_t                    wr,
    input  logic                                      rd_en,
    input  logic [wsfs_pkg::idx_w(LED_COUNT)-1:0]     rd_addr,
    output logic [wsfs_pkg::PIX_W-1:0]                rd_pixel
);
    import wsfs_pkg::*;

    localparam int LANES  = WSFS_LANES;
    localparam int LANE_W = $clog2(LANES);
    localparam int ROWS   = (LED_COUNT + LANES - 1) / LANES;
    localparam int ROW_W  = idx_w(ROWS);

    logic [LANES-1:0][PIX_W-1:0] mem [ROWS];
    logic [ROWS-1:0]             row_valid_reg;

    logic [LANES-1:0][PIX_W-1:0] rd_data_reg;
    logic [LANE_W-1:0]           rd_lane_reg;
    logic                        rd_valid_reg;

    logic [ROW_W-1:0]  wr_row;
    logic [LANE_W-1:0] wr_lane;
    logic [ROW_W-1:0]  rd_row;

    assign wr_row  = ROW_W'(wr.idx >> LANE_W);
    assign wr_lane = LANE_W'(wr.idx);
    assign rd_row  = ROW_W'(rd_addr >> LANE_W);

    // a row that is not valid reads as black; first write to it fills
    // the other lanes with zero
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            for (int l = 0; l < LANES; l++) begin
                if (!row_valid_reg[wr_row] || (LANE_W'(l) == wr_lane)) begin
                    mem[wr_row][l] <= (LANE_W'(l) == wr_lane) ? wr.pixel : '0;
                end
            end
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_row];
            rd_lane_reg  <= LANE_W'(rd_addr);
            rd_valid_reg <= !wr.clr_all && row_valid_reg[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (wr.clr_all) begin
            row_valid_reg <= '0;
        end else if (wr.en) begin
            row_valid_reg[wr_row] <= 1'b1;
        end
    end

    assign rd_pixel = rd_valid_reg ? rd_data_reg[rd_lane_reg] : '0;

endmodule

[hw/rtl/wsfs_out_skid.sv]
// Result output register with a skid stage.
module wsfs_out_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  wsfs_pkg::wsfs_out_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wsfs_pkg::wsfs_out_t out_data
);
    import wsfs_pkg::*;

    logic      out_valid_reg;
    logic      skid_valid_reg;
    wsfs_out_t out_data_reg;
    wsfs_out_t skid_data_reg;
    logic      in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
